// File: hdl/bts_pkg.sv
`default_nettype none

package bts_pkg;

    // Fixed field widths of the command and result words.
    localparam int FRAC_W    = 16;
    localparam int COORD_W   = FRAC_W + 1;
    localparam int DIM_W     = 9;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int NUM_BANKS = 4;
    localparam int BANK_W    = 2;

    // 1.0 in the coordinate format.
    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_W;

    // Reset value of both size registers.
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    typedef enum logic
    {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    typedef enum logic [0:0]
    {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    // Command word.
    typedef struct packed
    {
        func_t              func;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic [CH_W-1:0]    in_red;
        logic [CH_W-1:0]    in_green;
        logic [CH_W-1:0]    in_blue;
        logic [CH_W-1:0]    in_alpha;
        logic [COORD_W-1:0] u_coord;
        logic [COORD_W-1:0] v_coord;
    } cmd_word_t;

    // Result word.
    typedef struct packed
    {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } result_word_t;

    // Tap selection that travels alongside the bank read data.
    typedef struct packed
    {
        logic              valid;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
        logic              x0_par;
        logic              x1_par;
        logic              y0_par;
        logic              y1_par;
    } tap_sel_t;

    // Floor of a + (b - a) * f / 2^FRAC_W, always within [min(a,b), max(a,b)].
    function automatic logic [CH_W-1:0] lerp8(
        input logic [CH_W-1:0]   a,
        input logic [CH_W-1:0]   b,
        input logic [FRAC_W-1:0] f
    );
        logic signed [CH_W:0]          diff;
        logic signed [CH_W+FRAC_W+1:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        acc  = $signed({2'b00, a, {FRAC_W{1'b0}}}) + diff * $signed({1'b0, f});
        return acc[FRAC_W +: CH_W];
    endfunction

endpackage

`default_nettype wire

// File: hdl/bilinear_texture_sampler_top.sv
`default_nettype none

// Bilinear texture sampler with clamp-to-edge addressing over an RGBA8 image.
// Command channel: a word on cmd is taken at a clock edge with start high and
// busy low. busy never rises, so one command word can be taken every cycle.
// A write command stores one pixel and gives no result; a write outside the
// configured width and height is dropped. A sample command gives one result.
// Result channel: result holds a word for exactly one cycle, marked by
// result_valid; a sample passes the scaling multiply, bank read, horizontal
// pass and vertical pass registers in that order. Results come back in
// command order at up to one per cycle; the receiver cannot stall.
// The image sits in four single-port-read banks split by x and y parity, so
// the four neighbors of a sample are read at once. A write reaches its
// bank at the same pipeline point where later samples read, so a sample
// issued right after a write sees the new pixel.
// Configuration: cfg_index selects image_width or image_height; a word is
// written when cfg_valid and cfg_ready are high. Write it only while idle.
// Reset sets both sizes to 256 and empties the pipeline; pixel contents are
// undefined until written and no clearing pass is made.
module bilinear_texture_sampler_top
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_word_t        cmd,
    output logic                  result_valid,
    output result_word_t          result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire cfg_idx_t         cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data
);

    localparam int XW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
    localparam int YW = (MAX_HEIGHT > 4) ? $clog2(MAX_HEIGHT) : 2;
    localparam int AW = XW + YW - 2;
    localparam int BANK_DEPTH = 1 << AW;

    logic                 cmd_accept;
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [NUM_BANKS-1:0] bank_we;
    logic [AW-1:0]        bank_waddr;
    logic [PIX_W-1:0]     bank_wdata;
    logic [AW-1:0]        bank_raddr [NUM_BANKS];
    logic [PIX_W-1:0]     bank_rdata [NUM_BANKS];
    tap_sel_t             sel;

    assign busy       = 1'b0;
    assign cfg_ready  = 1'b1;
    assign cmd_accept = start && !busy;

    // Size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Coordinate scaling, neighbor addressing and write steering.
    bts_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (cmd_accept),
        .cmd          (cmd),
        .image_width  (width_reg),
        .image_height (height_reg),
        .bank_we      (bank_we),
        .bank_waddr   (bank_waddr),
        .bank_wdata   (bank_wdata),
        .bank_raddr   (bank_raddr),
        .sel          (sel)
    );

    // Pixel banks, one per x and y parity pair.
    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        bts_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr),
            .wdata (bank_wdata),
            .raddr (bank_raddr[b]),
            .rdata (bank_rdata[b])
        );
    end

    // Two-pass interpolation and the result register.
    bts_filter u_filter (
        .clk          (clk),
        .rst_n        (rst_n),
        .sel          (sel),
        .bank_rdata   (bank_rdata),
        .result_valid (result_valid),
        .result       (result)
    );

    // Every sample command returns a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && cmd.func == FUNC_SAMPLE) |-> ##4 result_valid)
        else $error("sample command without a result");

    // A result only ever follows a sample command.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd_accept && cmd.func == FUNC_SAMPLE, 4))
        else $error("result without a sample command");

    // A pixel write never lands in more than one bank.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("pixel write steered to several banks");

endmodule

`default_nettype wire

// File: hdl/bts_ram.sv
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/bts_addr.sv
`default_nettype none

module bts_addr
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    localparam int XW = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2,
    localparam int YW = (MAX_HEIGHT > 4) ? $clog2(MAX_HEIGHT) : 2,
    localparam int AW = XW + YW - 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire cmd_word_t            cmd,
    input  wire logic [DIM_W-1:0]     image_width,
    input  wire logic [DIM_W-1:0]     image_height,
    output logic      [NUM_BANKS-1:0] bank_we,
    output logic      [AW-1:0]        bank_waddr,
    output logic      [PIX_W-1:0]     bank_wdata,
    output logic      [AW-1:0]        bank_raddr [NUM_BANKS],
    output tap_sel_t                  sel
);

    // Index width: holds the largest size and any size register value.
    localparam int IW0 = (XW > YW) ? XW + 1 : YW + 1;
    localparam int IW  = (IW0 > DIM_W) ? IW0 : DIM_W;
    localparam int PW  = COORD_W + IW;
    localparam logic [IW-1:0] MAXW_I = IW'(MAX_WIDTH);
    localparam logic [IW-1:0] MAXH_I = IW'(MAX_HEIGHT);

    logic [IW-1:0]      w_eff;
    logic [IW-1:0]      h_eff;
    logic [COORD_W-1:0] u_clamp;
    logic [COORD_W-1:0] v_clamp;
    logic [IW-1:0]      wx_ext;
    logic [IW-1:0]      wy_ext;
    logic               wr_ok;

    logic               sample_reg;
    logic               wr_ok_reg;
    logic [PW-1:0]      pu_reg;
    logic [PW-1:0]      pv_reg;
    logic [IW-1:0]      wm1_reg;
    logic [IW-1:0]      hm1_reg;
    logic [IW-1:0]      wx_reg;
    logic [IW-1:0]      wy_reg;
    logic [PIX_W-1:0]   wdata_reg;

    logic [IW-1:0]      x0_raw;
    logic [IW-1:0]      y0_raw;
    logic [IW-1:0]      x0;
    logic [IW-1:0]      x1;
    logic [IW-1:0]      y0;
    logic [IW-1:0]      y1;

    tap_sel_t           sel_reg;

    // Effective sizes: zero counts as one, large values saturate.
    always_comb
    begin
        w_eff = IW'(image_width);
        h_eff = IW'(image_height);
        if (w_eff == '0)
        begin
            w_eff = IW'(1);
        end
        else if (w_eff > MAXW_I)
        begin
            w_eff = MAXW_I;
        end
        if (h_eff == '0)
        begin
            h_eff = IW'(1);
        end
        else if (h_eff > MAXH_I)
        begin
            h_eff = MAXH_I;
        end
    end

    // Coordinate clamp and write range check ahead of the scaling multiply.
    assign u_clamp = (cmd.u_coord > COORD_ONE) ? COORD_ONE : cmd.u_coord;
    assign v_clamp = (cmd.v_coord > COORD_ONE) ? COORD_ONE : cmd.v_coord;
    assign wx_ext  = IW'(cmd.pixel_x);
    assign wy_ext  = IW'(cmd.pixel_y);
    assign wr_ok   = accept && (cmd.func == FUNC_WRITE) && (wx_ext < w_eff) && (wy_ext < h_eff);

    // Stage A control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= 1'b0;
            wr_ok_reg  <= 1'b0;
        end
        else
        begin
            sample_reg <= accept && (cmd.func == FUNC_SAMPLE);
            wr_ok_reg  <= wr_ok;
        end
    end

    // Stage A payload: scaled coordinates and the pixel to store.
    always_ff @(posedge clk)
    begin
        pu_reg    <= PW'(u_clamp) * PW'(w_eff - IW'(1));
        pv_reg    <= PW'(v_clamp) * PW'(h_eff - IW'(1));
        wm1_reg   <= w_eff - IW'(1);
        hm1_reg   <= h_eff - IW'(1);
        wx_reg    <= wx_ext;
        wy_reg    <= wy_ext;
        wdata_reg <= {cmd.in_alpha, cmd.in_blue, cmd.in_green, cmd.in_red};
    end

    // Integer parts and the clamped right and lower neighbors.
    always_comb
    begin
        x0_raw = pu_reg[FRAC_W +: IW];
        y0_raw = pv_reg[FRAC_W +: IW];
        x0 = (x0_raw > wm1_reg) ? wm1_reg : x0_raw;
        y0 = (y0_raw > hm1_reg) ? hm1_reg : y0_raw;
        x1 = (x0 < wm1_reg) ? x0 + IW'(1) : wm1_reg;
        y1 = (y0 < hm1_reg) ? y0 + IW'(1) : hm1_reg;
    end

    // Each bank holds one parity pair, so neighbors that differ come from different banks.
    always_comb
    begin
        logic [IW-1:0] cx;
        logic [IW-1:0] cy;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            cx = (x0[0] == b[0]) ? x0 : x1;
            cy = (y0[0] == b[1]) ? y0 : y1;
            bank_raddr[b] = {cy[YW-1:1], cx[XW-1:1]};
            bank_we[b]    = wr_ok_reg && (wx_reg[0] == b[0]) && (wy_reg[0] == b[1]);
        end
    end

    assign bank_waddr = {wy_reg[YW-1:1], wx_reg[XW-1:1]};
    assign bank_wdata = wdata_reg;

    // Tap selection, aligned with the bank read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= '0;
        end
        else
        begin
            sel_reg.valid  <= sample_reg;
            sel_reg.frac_x <= pu_reg[FRAC_W-1:0];
            sel_reg.frac_y <= pv_reg[FRAC_W-1:0];
            sel_reg.x0_par <= x0[0];
            sel_reg.x1_par <= x1[0];
            sel_reg.y0_par <= y0[0];
            sel_reg.y1_par <= y1[0];
        end
    end

    assign sel = sel_reg;

endmodule

`default_nettype wire

// File: hdl/bts_filter.sv
`default_nettype none

module bts_filter
    import bts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tap_sel_t         sel,
    input  wire logic [PIX_W-1:0] bank_rdata [NUM_BANKS],
    output logic                  result_valid,
    output result_word_t          result
);

    logic [PIX_W-1:0]  p00;
    logic [PIX_W-1:0]  p10;
    logic [PIX_W-1:0]  p01;
    logic [PIX_W-1:0]  p11;
    logic [PIX_W-1:0]  top_next;
    logic [PIX_W-1:0]  bot_next;
    logic [PIX_W-1:0]  out_next;

    logic              h_valid_reg;
    logic [PIX_W-1:0]  top_reg;
    logic [PIX_W-1:0]  bot_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_reg;

    // Pick the four neighbors out of the banks by their parities.
    assign p00 = bank_rdata[{sel.y0_par, sel.x0_par}];
    assign p10 = bank_rdata[{sel.y0_par, sel.x1_par}];
    assign p01 = bank_rdata[{sel.y1_par, sel.x0_par}];
    assign p11 = bank_rdata[{sel.y1_par, sel.x1_par}];

    // Horizontal pass on the upper and lower row, every channel in parallel.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            top_next[c*CH_W +: CH_W] = lerp8(p00[c*CH_W +: CH_W], p10[c*CH_W +: CH_W],
                                             sel.frac_x);
            bot_next[c*CH_W +: CH_W] = lerp8(p01[c*CH_W +: CH_W], p11[c*CH_W +: CH_W],
                                             sel.frac_x);
        end
    end

    // Vertical pass.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            out_next[c*CH_W +: CH_W] = lerp8(top_reg[c*CH_W +: CH_W],
                                             bot_reg[c*CH_W +: CH_W], fy_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg   <= sel.valid;
            out_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        bot_reg <= bot_next;
        fy_reg  <= sel.frac_y;
        out_reg <= out_next;
    end

    // Red leads the result word.
    assign result_valid = out_valid_reg;
    assign result       = {out_reg[0*CH_W +: CH_W], out_reg[1*CH_W +: CH_W],
                           out_reg[2*CH_W +: CH_W], out_reg[3*CH_W +: CH_W]};

endmodule

`default_nettype wire
